/* hw/rtl/mseu_pkg.sv */
// package for the mips subset execute unit: payload structs, opcodes, status codes
// no dependencies
`timescale 1ns / 1ps
package mseu_pkg;
	localparam int RegCount = 32;
	localparam int PcW = 16;
	localparam int NpcW = 17;

	typedef struct packed {
		logic [31:0] instruction_word;
		logic [15:0] instruction_pc;
	} in_item_t;

	typedef struct packed {
		logic [16:0] next_pc;
		logic [2:0] status;
		logic [1:0] print_kind;
		logic signed [31:0] print_value;
		logic reg_written;
		logic [4:0] written_index;
		logic signed [31:0] written_value;
		logic signed [31:0] hi_value;
		logic signed [31:0] lo_value;
	} out_item_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_BRANCH = 3'd3;
	localparam logic [2:0] ST_SYSCALL = 3'd4;

	localparam logic [1:0] PK_NONE = 2'd0;
	localparam logic [1:0] PK_INT = 2'd1;
	localparam logic [1:0] PK_CHAR = 2'd2;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_ORI = 6'h0D;
	localparam logic [5:0] OP_LUI = 6'h0F;
	localparam logic [5:0] OP_BEQ = 6'h04;
	localparam logic [5:0] OP_BNE = 6'h05;

	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_SLT = 6'h2A;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_DIV = 6'h1A;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MUL = 6'h02;

	localparam logic [31:0] SYS_PRINT_INT = 32'd1;
	localparam logic [31:0] SYS_EXIT = 32'd10;
	localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;
endpackage

/* hw/rtl/mseu_div.sv */
// iterative signed divider, one quotient bit a cycle
// no dependencies: mseu_pkg is not imported
`timescale 1ns / 1ps
module mseu_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [31:0] quot,
	output logic [31:0] rem
);
	logic busy_q;
	logic [5:0] cnt_q;
	logic [31:0] q_q, r_q, d_q;
	logic neg_q_q, neg_r_q;
	logic [32:0] trial;
	logic [31:0] r_shift;

	assign r_shift = {r_q[30:0], q_q[31]};
	assign trial = {1'b0, r_shift} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend[31] ? (~dividend + 32'd1) : dividend;
			d_q <= divisor[31] ? (~divisor + 32'd1) : divisor;
			r_q <= '0;
			neg_q_q <= dividend[31] ^ divisor[31];
			neg_r_q <= dividend[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_shift;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quot = neg_q_q ? (~q_q + 32'd1) : q_q;
	assign rem = neg_r_q ? (~r_q + 32'd1) : r_q;
endmodule

/* hw/rtl/mips_subset_execute_unit_top.sv */
// channel | signals                      | accepted when
// cfg     | cfg_valid cfg_ready cfg_data | valid & ready
// in      | in_valid in_stall in_data    | valid & !stall
// out     | out_valid out_stall out_data | valid & !stall
// one instruction at a time: read rs/rt from the register memory, decode/execute, mult and
// mul through the multiply state, div in mseu_div, then write back and offer the result;
// the next beat is taken the cycle after the result beat. reset zeroes HI, LO and
// program_length; the register memory is cleared by a pass over every register after
// reset before the first beat is taken. a stalled output holds the unit.
// depends on mseu_pkg and mseu_div
`timescale 1ns / 1ps
module mips_subset_execute_unit_top #(
	parameter int REG_COUNT = mseu_pkg::RegCount
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [16:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input mseu_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output mseu_pkg::out_item_t out_data
);
	import mseu_pkg::*;

	localparam int IdxW = $clog2(REG_COUNT);

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_EX = 3'd3;
	localparam logic [2:0] S_MUL = 3'd4;
	localparam logic [2:0] S_DIV = 3'd5;
	localparam logic [2:0] S_WB = 3'd6;
	localparam logic [2:0] S_OUT = 3'd7;

	logic [2:0] state_q;
	logic [IdxW:0] clr_q;
	logic [16:0] plen_q;
	logic [31:0] hi_q, lo_q;
	logic [31:0] word_q;
	logic [15:0] pc_q;
	logic [31:0] rf [REG_COUNT];
	logic [31:0] a_q, b_q;
	logic [IdxW-1:0] ra_idx, rb_idx;
	logic mul_s1;
	logic [63:0] prod_s1;
	out_item_t res_q;

	// register memory port
	logic we;
	logic [IdxW-1:0] wa;
	logic [31:0] wd;

	logic [5:0] op, fn;
	logic [IdxW-1:0] rs, rt, rd;
	assign op = word_q[31:26];
	assign fn = word_q[5:0];
	assign rs = word_q[21 +: IdxW];
	assign rt = word_q[16 +: IdxW];
	assign rd = word_q[11 +: IdxW];

	// syscall needs $v0/$a0 instead of rs/rt
	logic is_sys;
	assign is_sys = (op == OP_SPECIAL) && (fn == FN_SYSCALL);
	assign ra_idx = is_sys ? IdxW'(2) : rs;
	assign rb_idx = is_sys ? IdxW'(4) : rt;

	always_ff @(posedge clk) begin
		if (we) rf[wa] <= wd;
		a_q <= rf[ra_idx];
		b_q <= rf[rb_idx];
	end

	logic div_start, div_done;
	logic [31:0] div_q, div_r;
	mseu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(a_q), .divisor(b_q),
		.done(div_done), .quot(div_q), .rem(div_r)
	);

	logic [31:0] a, b, simm;
	assign a = (rs == '0) ? 32'd0 : a_q;
	assign b = (rt == '0) ? 32'd0 : b_q;
	assign simm = {{16{word_q[15]}}, word_q[15:0]};

	// execute decode
	out_item_t ex;
	logic ex_wr;
	logic [IdxW-1:0] ex_idx;
	logic [31:0] ex_val;
	logic go_mul, go_div;
	logic [17:0] tgt;
	always_comb begin
		ex = '0;
		ex_wr = 1'b0;
		ex_idx = rd;
		ex_val = '0;
		go_mul = 1'b0;
		go_div = 1'b0;
		ex.next_pc = {1'b0, pc_q} + 17'd1;
		ex.status = ST_OK;
		ex.hi_value = hi_q;
		ex.lo_value = lo_q;
		tgt = {2'b0, pc_q} + {simm[17:0]};
		unique case (op)
			OP_SPECIAL: begin
				unique case (fn)
					FN_ADD: begin ex_wr = 1'b1; ex_val = a + b; end
					FN_SUB: begin ex_wr = 1'b1; ex_val = a - b; end
					FN_SLT: begin ex_wr = 1'b1; ex_val = {31'd0, $signed(a) < $signed(b)}; end
					FN_MULT: go_mul = 1'b1;
					FN_DIV: go_div = (b != 32'd0);
					FN_MFHI: begin ex_wr = 1'b1; ex_val = hi_q; end
					FN_MFLO: begin ex_wr = 1'b1; ex_val = lo_q; end
					FN_SYSCALL: begin
						if (a_q == SYS_PRINT_INT) begin
							ex.print_kind = PK_INT;
							ex.print_value = b_q;
						end else if (a_q == SYS_PRINT_CHAR) begin
							ex.print_kind = PK_CHAR;
							ex.print_value = {24'd0, b_q[7:0]};
						end else if (a_q == SYS_EXIT) ex.status = ST_HALT;
						else ex.status = ST_SYSCALL;
					end
					default: ex.status = ST_INVALID;
				endcase
			end
			OP_SPECIAL2: begin
				if (fn == FN_MUL) go_mul = 1'b1;
				else ex.status = ST_INVALID;
			end
			OP_ADDI: begin ex_wr = 1'b1; ex_idx = rt; ex_val = a + simm; end
			OP_ORI: begin ex_wr = 1'b1; ex_idx = rt; ex_val = a | {16'd0, word_q[15:0]}; end
			OP_LUI: begin ex_wr = 1'b1; ex_idx = rt; ex_val = {word_q[15:0], 16'd0}; end
			OP_BEQ, OP_BNE: begin
				if ((op == OP_BEQ) == (a == b)) begin
					// target is 18-bit signed: negative shows in bit 17
					if (tgt[17] || (tgt[16:0] > plen_q)) ex.status = ST_BRANCH;
					else ex.next_pc = tgt[16:0];
				end
			end
			default: ex.status = ST_INVALID;
		endcase
		if (ex.status != ST_OK) begin
			ex.next_pc = {1'b0, pc_q};
			ex_wr = 1'b0;
		end
		if (ex_wr && ex_idx != '0) begin
			ex.reg_written = 1'b1;
			ex.written_index = 5'(ex_idx);
			ex.written_value = ex_val;
		end
	end

	assign div_start = (state_q == S_EX) && go_div;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		we = 1'b0;
		wa = rd;
		wd = '0;
		if (state_q == S_CLR) begin
			we = 1'b1;
			wa = clr_q[IdxW-1:0];
		end else if (state_q == S_WB && res_q.reg_written) begin
			we = 1'b1;
			wa = res_q.written_index[IdxW-1:0];
			wd = res_q.written_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			plen_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			mul_s1 <= 1'b0;
		end else begin
			if (cfg_valid) plen_q <= cfg_data;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IdxW+1)'(REG_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) state_q <= S_RD;
				S_RD: state_q <= S_EX;
				S_EX: begin
					if (go_mul) begin
						state_q <= S_MUL;
						mul_s1 <= 1'b0;
					end else if (go_div) state_q <= S_DIV;
					else state_q <= S_WB;
				end
				S_MUL: begin
					mul_s1 <= 1'b1;
					if (mul_s1) begin
						state_q <= S_WB;
						if (op == OP_SPECIAL) begin
							hi_q <= prod_s1[63:32];
							lo_q <= prod_s1[31:0];
						end
					end
				end
				S_DIV: if (div_done) begin
					hi_q <= div_r;
					lo_q <= div_q;
					state_q <= S_WB;
				end
				S_WB: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			word_q <= in_data.instruction_word;
			pc_q <= in_data.instruction_pc;
		end
		if (state_q == S_EX) begin
			prod_s1 <= $signed(a) * $signed(b);
			res_q <= ex;
		end
		if (state_q == S_MUL && mul_s1) begin
			if (op == OP_SPECIAL) begin
				res_q.hi_value <= prod_s1[63:32];
				res_q.lo_value <= prod_s1[31:0];
			end else if (rd != '0) begin
				res_q.reg_written <= 1'b1;
				res_q.written_index <= 5'(rd);
				res_q.written_value <= prod_s1[31:0];
			end
		end
		if (state_q == S_DIV && div_done) begin
			res_q.hi_value <= div_r;
			res_q.lo_value <= div_q;
		end
	end

`ifndef SYNTHESIS
	a_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && res_q.reg_written) |-> (res_q.written_index != 5'd0))
		else $error("write to register zero");
	a_fail_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> !out_data.reg_written)
		else $error("failed instruction wrote a register");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
`endif
endmodule
